// ===== src/lfrf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfrf_pkg
// Shared types and constants of the line-framed receive FIFO.
// ----------------------------------------------------------------------------
package lfrf_pkg;

  localparam int FIFO_DEPTH = 256;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LIMIT_W    = 9;
  localparam int CNT_W      = 8;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic KIND_RX   = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(256);

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    RES_WRITE,
    RES_NOLINE,
    RES_CHAR,
    RES_END
  } res_sel_t;

  typedef struct packed {
    logic     wr_en;
    logic     rp_inc;
    logic     cnt_inc;
    logic     line_clr;
    logic     out_load;
    res_sel_t res_sel;
  } lfrf_cmd_t;

  typedef struct packed {
    logic flag;
    logic full;
    logic empty;
    logic cap_hit;
    logic rd_eol;
    logic out_busy;
  } lfrf_stat_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

endpackage
`default_nettype wire

// ===== src/line_framed_receive_fifo_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// line_framed_receive_fifo_unit
// Receive byte ring with one line-ready flag; hands out a line char by char.
// ----------------------------------------------------------------------------
//  channel | ports        | tdata (low bit up)               | tuser / tlast
//  in      | in_t*        | rx_byte[7:0]                     | tuser: kind
//  out     | out_t*       | accepted, char_out[7:0],         | tuser: char_valid,
//          |              | line_nonempty, 6 zero bits       |   no_line; tlast: line_end
//  cfg     | cfg_we/wdata | line_limit[8:0]                  | -
//
//  A received byte and a read with no line ready load the result from S_IDLE. A line
//  character is loaded from S_CHAR, after the registered read of the ring. A line end
//  is loaded from S_FCHK; when a CR/LF ends the line it passes S_CHAR and S_FWAIT first,
//  and each further CR/LF flushed from the head adds an S_FWAIT, S_FCHK pass (single ring read port).
//  Reset clears pointers, flag, count and limit (256); the ring is not cleared.
//  No beat is taken while a read is in progress or a result is held unread.
// ----------------------------------------------------------------------------
module line_framed_receive_fifo_unit (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire  [lfrf_pkg::LIMIT_W-1:0] cfg_wdata,   // line_limit
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [7:0]                   in_tdata,    // rx_byte
  input  wire                          in_tuser,    // kind
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [15:0]                  out_tdata,   // accepted, char_out, line_nonempty, pad
  output logic [1:0]                   out_tuser,   // char_valid, no_line
  output logic                         out_tlast    // line_end
);
  import lfrf_pkg::*;

  lfrf_cmd_t  cmd;
  lfrf_stat_t stat;
  logic       res_accepted, res_char_valid, res_line_end, res_nonempty, res_no_line;
  logic [7:0] res_char;

  lfrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  lfrf_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .rx_byte        (in_tdata),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_tvalid),
    .out_tready     (out_tready),
    .res_accepted   (res_accepted),
    .res_char       (res_char),
    .res_char_valid (res_char_valid),
    .res_line_end   (res_line_end),
    .res_nonempty   (res_nonempty),
    .res_no_line    (res_no_line)
  );

  assign out_tdata = {6'b0, res_nonempty, res_char, res_accepted};
  assign out_tuser = {res_no_line, res_char_valid};
  assign out_tlast = res_line_end;

endmodule
`default_nettype wire

// ===== src/lfrf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfrf_ctrl
// Sequencer: takes beats, steps the line read and the CR/LF flush.
// ----------------------------------------------------------------------------
module lfrf_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire                 in_kind,
  input  lfrf_pkg::lfrf_stat_t stat,
  output lfrf_pkg::lfrf_cmd_t  cmd
);
  import lfrf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHAR  = 4'b0010,
    S_FWAIT = 4'b0100,
    S_FCHK  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_acc;

  assign in_tready = (state_r == S_IDLE) && !stat.out_busy;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_sel = RES_WRITE;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_RX) begin
            cmd.wr_en    = !stat.full;
            cmd.out_load = 1'b1;
            cmd.res_sel  = RES_WRITE;
          end else if (!stat.flag) begin
            cmd.out_load = 1'b1;
            cmd.res_sel  = RES_NOLINE;
          end else if (!stat.empty && !stat.cap_hit) begin
            state_nxt = S_CHAR;
          end else begin
            // head byte already sits in the read register
            state_nxt = S_FCHK;
          end
        end
      end
      S_CHAR: begin
        cmd.rp_inc = 1'b1;
        if (!stat.rd_eol) begin
          cmd.cnt_inc  = 1'b1;
          cmd.out_load = 1'b1;
          cmd.res_sel  = RES_CHAR;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_FWAIT;
        end
      end
      S_FWAIT: begin
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (!stat.empty && stat.rd_eol) begin
          cmd.rp_inc = 1'b1;
          state_nxt  = S_FWAIT;
        end else begin
          cmd.line_clr = 1'b1;
          cmd.out_load = 1'b1;
          cmd.res_sel  = RES_END;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/lfrf_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfrf_datapath
// Byte ring, pointers, line flag, char count, limit register, result register.
// ----------------------------------------------------------------------------
module lfrf_datapath (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [lfrf_pkg::LIMIT_W-1:0]     cfg_wdata,
  input  wire  [7:0]                       rx_byte,
  input  lfrf_pkg::lfrf_cmd_t              cmd,
  output lfrf_pkg::lfrf_stat_t             stat,
  output logic                             out_valid,
  input  wire                              out_tready,
  output logic                             res_accepted,
  output logic [7:0]                       res_char,
  output logic                             res_char_valid,
  output logic                             res_line_end,
  output logic                             res_nonempty,
  output logic                             res_no_line
);
  import lfrf_pkg::*;

  logic [7:0]         byte_store_r [FIFO_DEPTH];
  logic [7:0]         rd_data_r;
  ptr_t               wp_r, rp_r;
  logic               flag_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [LIMIT_W-1:0] limit_r;
  logic               out_valid_r;
  logic               acc_r, cv_r, le_r, ne_r, nl_r;
  logic [7:0]         ch_r;

  logic [LIMIT_W-1:0] cap;
  logic               full, empty;

  assign full  = (ptr_next(wp_r) == rp_r);
  assign empty = (rp_r == wp_r);

  // per-line character cap: limit-1, zero for limit 0, saturated at 255
  always_comb begin
    cap = (limit_r == '0) ? '0 : limit_r - 1'b1;
    if (cap > LIMIT_W'(255)) cap = LIMIT_W'(255);
  end

  assign stat.flag     = flag_r;
  assign stat.full     = full;
  assign stat.empty    = empty;
  assign stat.cap_hit  = ({1'b0, cnt_r} >= cap);
  assign stat.rd_eol   = is_eol(rd_data_r);
  assign stat.out_busy = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      byte_store_r[wp_r] <= rx_byte;
    end
    rd_data_r <= byte_store_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      flag_r      <= 1'b0;
      cnt_r       <= '0;
      limit_r     <= LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      if (cmd.wr_en) begin
        wp_r <= ptr_next(wp_r);
        if (rx_byte == CH_LF) flag_r <= 1'b1;
      end
      if (cmd.rp_inc) rp_r <= ptr_next(rp_r);
      if (cmd.line_clr) begin
        flag_r <= 1'b0;
        cnt_r  <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      acc_r <= (cmd.res_sel == RES_WRITE) && !full;
      ch_r  <= (cmd.res_sel == RES_CHAR) ? rd_data_r : 8'h00;
      cv_r  <= (cmd.res_sel == RES_CHAR);
      le_r  <= (cmd.res_sel == RES_END);
      ne_r  <= (cmd.res_sel == RES_END) && (cnt_r != '0);
      nl_r  <= (cmd.res_sel == RES_NOLINE);
    end
  end

  assign out_valid      = out_valid_r;
  assign res_accepted   = acc_r;
  assign res_char       = ch_r;
  assign res_char_valid = cv_r;
  assign res_line_end   = le_r;
  assign res_nonempty   = ne_r;
  assign res_no_line    = nl_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_tready))
    else $error("result register overwritten while held");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !full)
    else $error("byte stored into full ring");

  a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rp_inc |-> !empty)
    else $error("read pointer advanced past write pointer");

endmodule
`default_nettype wire

// ===== sim/line_fifo_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// line_fifo_checker
// Watches the in/out/cfg ports of the line-framed receive FIFO, keeps its
// own copy of the ring, pointers, line flag and limit, predicts one result
// per accepted input beat and compares each output beat field by field.
// ----------------------------------------------------------------------------
module line_fifo_checker (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire  [lfrf_pkg::LIMIT_W-1:0] cfg_wdata,
  input  wire                          in_tvalid,
  input  wire                          in_tready,
  input  wire  [7:0]                   in_tdata,    // rx_byte
  input  wire                          in_tuser,    // kind
  input  wire                          out_tvalid,
  input  wire                          out_tready,
  input  wire  [15:0]                  out_tdata,   // accepted, char_out, line_nonempty, pad
  input  wire  [1:0]                   out_tuser,   // char_valid, no_line
  input  wire                          out_tlast,   // line_end
  output int                           err_count,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lfrf_pkg::*;

  typedef struct packed {
    logic       accepted;
    logic [7:0] char_out;
    logic       char_valid;
    logic       line_end;
    logic       line_nonempty;
    logic       no_line;
  } line_res_t;

  line_res_t          line_results_q[$];
  logic [7:0]         ring_copy [FIFO_DEPTH];
  int                 wr_pos;
  int                 rd_pos;
  int                 chars_out;
  int                 cap;
  int                 mismatches;
  logic               flag_copy;
  logic [LIMIT_W-1:0] limit_copy;
  logic [7:0]         c;
  logic               took;
  line_res_t          want;
  line_res_t          got;

  always @(posedge clk) begin
    if (!rst_n) begin
      wr_pos     = 0;
      rd_pos     = 0;
      chars_out  = 0;
      flag_copy  = 1'b0;
      limit_copy = LIMIT_RST;
      mismatches = 0;
      line_results_q.delete();
    end else begin
      if (cfg_we)
        limit_copy = cfg_wdata;

      if (in_tvalid && in_tready) begin
        want = '0;
        if (in_tuser == KIND_RX) begin
          // one slot stays free: full when the next write slot is the read slot
          if ((wr_pos + 1) % FIFO_DEPTH != rd_pos) begin
            ring_copy[wr_pos] = in_tdata;
            wr_pos = (wr_pos + 1) % FIFO_DEPTH;
            if (in_tdata == CH_LF)
              flag_copy = 1'b1;
            want.accepted = 1'b1;
          end
        end else if (!flag_copy) begin
          want.no_line = 1'b1;
        end else begin
          took = 1'b0;
          cap = (limit_copy == 0) ? 0 : int'(limit_copy) - 1;
          if (cap > 255)
            cap = 255;
          if (rd_pos != wr_pos && chars_out < cap) begin
            c = ring_copy[rd_pos];
            rd_pos = (rd_pos + 1) % FIFO_DEPTH;
            if (c != CH_LF && c != CH_CR) begin
              want.char_out   = c;
              want.char_valid = 1'b1;
              chars_out++;
              took = 1'b1;
            end
          end
          if (!took) begin
            // line end: drop CR/LF at the head, clear the flag
            while (rd_pos != wr_pos &&
                   (ring_copy[rd_pos] == CH_LF || ring_copy[rd_pos] == CH_CR))
              rd_pos = (rd_pos + 1) % FIFO_DEPTH;
            want.line_end      = 1'b1;
            want.line_nonempty = (chars_out > 0);
            flag_copy = 1'b0;
            chars_out  = 0;
          end
        end
        line_results_q.push_back(want);
      end

      if (out_tvalid && out_tready) begin
        got.accepted      = out_tdata[0];
        got.char_out      = out_tdata[8:1];
        got.line_nonempty = out_tdata[9];
        got.char_valid    = out_tuser[0];
        got.no_line       = out_tuser[1];
        got.line_end      = out_tlast;
        if (line_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR %0t: result beat with nothing expected:", $time,
                     " acc=%b chr=%h cv=%b end=%b ne=%b nol=%b",
                     got.accepted, got.char_out, got.char_valid,
                     got.line_end, got.line_nonempty, got.no_line);
        end else begin
          want = line_results_q.pop_front();
          if (got.accepted !== want.accepted || got.char_out !== want.char_out ||
              got.char_valid !== want.char_valid || got.line_end !== want.line_end ||
              got.line_nonempty !== want.line_nonempty || got.no_line !== want.no_line) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR %0t: expected acc=%b chr=%h cv=%b end=%b ne=%b nol=%b,",
                       $time, want.accepted, want.char_out, want.char_valid,
                       want.line_end, want.line_nonempty, want.no_line,
                       " got acc=%b chr=%h cv=%b end=%b ne=%b nol=%b",
                       got.accepted, got.char_out, got.char_valid,
                       got.line_end, got.line_nonempty, got.no_line);
          end
        end
      end
    end
    err_count <= mismatches;
    pending   <= line_results_q.size();
  end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Drives the line-framed receive FIFO with directed lines, a full-ring fill
// and random line traffic under several line limits, with random gaps on
// both sides and one long receiver hold-off. The checker beside the block
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lfrf_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata  = '0;
  logic               in_tvalid  = 1'b0;
  logic [7:0]         in_tdata   = '0;
  logic               in_tuser   = KIND_RX;
  logic               out_tready = 1'b0;
  wire                in_tready;
  wire                out_tvalid;
  wire  [15:0]        out_tdata;
  wire  [1:0]         out_tuser;
  wire                out_tlast;
  int                 err_count;
  int                 pending;

  logic idle_on   = 1'b1;
  logic hold_req  = 1'b0;
  bit   hold_done = 1'b0;
  int   beats_sent = 0;
  int   quiet_cycles = 0;

  line_framed_receive_fifo_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  line_fifo_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .err_count  (err_count),
    .pending    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    do
      b = 8'($urandom);
    while (b == CH_LF || b == CH_CR);
    return b;
  endfunction

  task automatic send_beat(input logic kind, input logic [7:0] data);
    int gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // limit changes only with the block drained
  task automatic write_limit(input logic [LIMIT_W-1:0] lim);
    in_tvalid <= 1'b0;
    // pending is a registered copy of the checker's queue size
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wdata <= lim;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int n_beats,
                           input logic idle, input logic hold);
    int cap;
    int small_max;
    int len;
    int nreads;
    int i;
    int pick;
    int stop;
    write_limit(lim);
    idle_on <= idle;
    if (hold)
      hold_req <= 1'b1;
    cap = (lim == 0) ? 0 : int'(lim) - 1;
    if (cap > 255)
      cap = 255;
    // keep most lines within the cap so the ring does not silt up
    small_max = (cap < 12) ? cap : 12;
    stop = beats_sent + n_beats;
    while (beats_sent < stop) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        len = $urandom_range(0, small_max);
        if (cap > 0 && $urandom_range(0, 7) == 0)
          len += $urandom_range(1, 3);
        if (cap >= 40 && $urandom_range(0, 15) == 0)
          len = $urandom_range(13, 40);
        for (i = 0; i < len; i++) begin
          if (cap >= 12 && $urandom_range(0, 29) == 0)
            send_beat(KIND_RX, CH_CR);
          else
            send_beat(KIND_RX, rand_text_byte());
        end
        if ($urandom_range(0, 3) == 0)
          send_beat(KIND_RX, CH_CR);
        send_beat(KIND_RX, CH_LF);
        nreads = len + $urandom_range(1, 3);
        for (i = 0; i < nreads; i++) begin
          if ($urandom_range(0, 5) == 0)
            send_beat(KIND_RX, rand_text_byte());
          send_beat(KIND_READ, 8'($urandom));
        end
      end else if (pick < 9) begin
        // noise: any kind, eol codes weighted up
        if ($urandom_range(0, 7) == 0)
          send_beat(1'($urandom_range(0, 1)), CH_LF);
        else if ($urandom_range(0, 7) == 0)
          send_beat(1'($urandom_range(0, 1)), CH_CR);
        else
          send_beat(1'($urandom_range(0, 1)), 8'($urandom));
      end else begin
        // unterminated fragment followed by reads
        len = $urandom_range(1, 4);
        for (i = 0; i < len; i++)
          send_beat(KIND_RX, rand_text_byte());
        nreads = $urandom_range(1, 3);
        for (i = 0; i < nreads; i++)
          send_beat(KIND_READ, 8'($urandom));
      end
    end
  endtask

  // result side: random stall per beat, one long hold-off on request
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        gap = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        gap = idle_on ? $urandom_range(0, 17) : 0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int i;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset limit
    send_beat(KIND_READ, 8'hFF);         // no line yet
    send_beat(KIND_RX, 8'h00);
    send_beat(KIND_RX, 8'hFF);
    send_beat(KIND_RX, 8'h41);
    send_beat(KIND_RX, CH_CR);
    send_beat(KIND_RX, 8'h42);
    send_beat(KIND_RX, CH_LF);
    send_beat(KIND_READ, 8'h00);
    send_beat(KIND_READ, 8'hFF);
    send_beat(KIND_READ, 8'h5A);
    send_beat(KIND_READ, 8'hA5);         // ends on CR, flag drops
    send_beat(KIND_READ, 8'h00);         // no line though bytes remain
    send_beat(KIND_RX, CH_LF);
    send_beat(KIND_RX, CH_LF);           // flag already up
    send_beat(KIND_READ, 8'h00);
    send_beat(KIND_READ, 8'h00);         // ends on LF, the two LFs behind it flushed
    send_beat(KIND_RX, CH_CR);
    send_beat(KIND_RX, CH_LF);
    send_beat(KIND_READ, 8'h00);         // empty line

    run_phase(9'd2,   30, 1'b1, 1'b0);
    run_phase(9'd3,   25, 1'b0, 1'b0);
    run_phase(9'd0,   8,  1'b1, 1'b0);
    run_phase(9'd1,   8,  1'b1, 1'b0);
    run_phase(9'd17,  50, 1'b1, 1'b1);
    run_phase(9'd511, 40, 1'b0, 1'b0);
    run_phase(9'd5,   30, 1'b1, 1'b0);
    run_phase(9'd256, 40, 1'b1, 1'b0);

    // fill the ring past full; the late LF and CR are dropped
    for (i = 0; i < 200; i++)
      send_beat(KIND_RX, rand_text_byte());
    send_beat(KIND_RX, CH_LF);
    for (i = 0; i < 60; i++)
      send_beat(KIND_RX, rand_text_byte());
    send_beat(KIND_RX, CH_LF);
    send_beat(KIND_RX, CH_CR);
    for (i = 0; i < 20; i++)
      send_beat(KIND_READ, 8'($urandom));

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
src/lfrf_pkg.sv
src/lfrf_ctrl.sv
src/lfrf_datapath.sv
src/line_framed_receive_fifo_unit.sv
sim/line_fifo_checker.sv
sim/testbench.sv
